// File: hdl/mcewt_pkg.sv
package mcewt_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 2;
  localparam int STAMP_W      = 16;
  localparam int LEVEL_W      = 3;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [1:0]         op_t;
  typedef logic [1:0]         status_t;

  localparam op_t OP_SAMPLE     = 2'd0;
  localparam op_t OP_PERIOD_END = 2'd1;
  localparam op_t OP_START      = 2'd2;

  localparam status_t ST_IDLE      = 2'd0;
  localparam status_t ST_MEASURING = 2'd1;
  localparam status_t ST_DONE      = 2'd2;

  localparam chan_t CH_FIRST = chan_t'(1);
  localparam chan_t CH_LAST  = chan_t'(NUM_CHANNELS);

  typedef struct packed {
    op_t                operation;
    stamp_t             timestamp;
    logic [LEVEL_W-1:0] echo_levels;
    chan_t              start_channel;
  } in_item_t;

  typedef struct packed {
    logic    trigger_pulse;
    logic    clear_timer;
    chan_t   active_channel;
    status_t status;
    stamp_t  distance_one;
    stamp_t  distance_two;
    stamp_t  distance_three;
  } out_item_t;

  function automatic chan_t clamp_channel(input chan_t ch);
    chan_t res;
    res = ch;
    if (ch < CH_FIRST) res = CH_FIRST;
    else if (ch > CH_LAST) res = CH_LAST;
    return res;
  endfunction

  function automatic chan_t next_channel(input chan_t ch);
    chan_t res;
    res = ch + CH_FIRST;
    if (ch >= CH_LAST) res = CH_FIRST;
    return res;
  endfunction

endpackage

// File: hdl/mcewt_regs.sv
module mcewt_regs
  import mcewt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  continuous_mode
);

  logic cont_r;
  logic cont_nxt;
  logic hit;

  assign hit    = (paddr[CFG_ADDR_W-1:2] == '0);
  assign pready = 1'b1;

  always_comb begin
    cont_nxt = cont_r;
    if (psel && penable && pwrite && hit) begin
      cont_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_r <= 1'b0;
    end else begin
      cont_r <= cont_nxt;
    end
  end

  assign prdata          = hit ? {{(CFG_DATA_W-1){1'b0}}, cont_r} : '0;
  assign continuous_mode = cont_r;

endmodule

// File: hdl/mcewt_in_stage.sv
module mcewt_in_stage
  import mcewt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     st_valid,
  output in_item_t st_data,
  input  logic     st_take
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  assign in_ready = !valid_r || st_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) valid_nxt = 1'b1;
    else if (st_take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign st_valid = valid_r;
  assign st_data  = data_r;

endmodule

// File: hdl/mcewt_core.sv
module mcewt_core
  import mcewt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      continuous_mode,
  input  logic      st_valid,
  input  in_item_t  st_data,
  output logic      st_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  chan_t     ch_r, ch_nxt;
  logic      prev_r, prev_nxt;
  stamp_t    rise_r, rise_nxt;
  stamp_t    fall_r, fall_nxt;
  stamp_t    width_r [NUM_CHANNELS];
  stamp_t    width_nxt [NUM_CHANNELS];
  status_t   status_r, status_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      trig, clr, lvl;
  chan_t     pos;

  assign st_take = st_valid && (!out_valid_r || out_ready);
  assign pos     = ch_r - CH_FIRST;
  assign lvl     = st_data.echo_levels[pos];

  always_comb begin
    ch_nxt     = ch_r;
    prev_nxt   = prev_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    width_nxt  = width_r;
    status_nxt = status_r;
    trig       = 1'b0;
    clr        = 1'b0;
    case (st_data.operation)
      OP_START: begin
        ch_nxt     = clamp_channel(st_data.start_channel);
        prev_nxt   = 1'b0;
        status_nxt = ST_MEASURING;
        trig       = 1'b1;
        clr        = 1'b1;
      end
      OP_SAMPLE: begin
        if (lvl && !prev_r) rise_nxt = st_data.timestamp;
        if (!lvl && prev_r) fall_nxt = st_data.timestamp;
        prev_nxt = lvl;
      end
      OP_PERIOD_END: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_r == chan_t'(i + 1)) width_nxt[i] = fall_r - rise_r;
        end
        status_nxt = ST_DONE;
        if (continuous_mode) begin
          ch_nxt   = next_channel(ch_r);
          prev_nxt = 1'b0;
          trig     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt.trigger_pulse  = trig;
    out_data_nxt.clear_timer    = clr;
    out_data_nxt.active_channel = ch_nxt;
    out_data_nxt.status         = status_nxt;
    out_data_nxt.distance_one   = width_nxt[0];
    out_data_nxt.distance_two   = width_nxt[1];
    out_data_nxt.distance_three = width_nxt[2];
    out_valid_nxt = out_valid_r;
    if (st_take) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= CH_FIRST;
      prev_r      <= 1'b0;
      rise_r      <= '0;
      fall_r      <= '0;
      status_r    <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) width_r[i] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (st_take) begin
        ch_r     <= ch_nxt;
        prev_r   <= prev_nxt;
        rise_r   <= rise_nxt;
        fall_r   <= fall_nxt;
        status_r <= status_nxt;
        width_r  <= width_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/multi_channel_echo_width_timer_top.sv
// channel   direction  payload      handshake
// in_       in         in_item_t    in_valid / in_ready
// out_      out        out_item_t   out_valid / out_ready
// cfg (APB) in         32-bit word  psel / penable / pwrite, pready tied high
//
// One beat per cycle sustained while the result is not stalled.
// The state update and result are formed in the single pass between the
// input register and the result register.
// Reset is synchronous, active low; no clearing pass.
// A stalled result holds the core; the input register takes one more beat.
module multi_channel_echo_width_timer_top
  import mcewt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic     continuous_mode;
  logic     st_valid;
  logic     st_take;
  in_item_t st_data;

  mcewt_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .continuous_mode (continuous_mode)
  );

  mcewt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .st_valid (st_valid),
    .st_data  (st_data),
    .st_take  (st_take)
  );

  mcewt_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .continuous_mode (continuous_mode),
    .st_valid        (st_valid),
    .st_data         (st_data),
    .st_take         (st_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

// File: hdl/mcewt_checker.sv
module mcewt_checker
  import mcewt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");

  a_clr_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clear_timer |->
      out_data.trigger_pulse && out_data.status == ST_MEASURING)
    else $error("timer clear without start");

  a_rescan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.trigger_pulse && !out_data.clear_timer |->
      out_data.status == ST_DONE)
    else $error("rescan trigger outside period end");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_IDLE |->
      out_data.distance_one == '0 && out_data.distance_two == '0 &&
      out_data.distance_three == '0)
    else $error("width stored while idle");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind multi_channel_echo_width_timer_top mcewt_checker u_chk (.*);
